// File: rtl/fvpcm_pkg.sv
// fvpcm_pkg: shared types, constants and the microcode table of the four-voice pcm player
// no dependencies; used by rtl/four_voice_pcm_sample_player.sv
`default_nettype none

package fvpcm_pkg;

    // default sizing of the block
    localparam int SAMPLE_ADDR_BITS_DEF = 20;
    localparam int VOICE_COUNT_DEF      = 4;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int OFS_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 20;
    localparam int POS_W    = 28;
    localparam int FRAC_W   = 8;
    localparam int STEP_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 18;
    localparam int PROD_W   = 16;
    localparam int HI_W     = 16;   // start and end keep bits 19:4

    // constants of the voice logic
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 16'd64;
    localparam logic [ADDR_W:0]    END_GUARD      = 21'h00020;
    localparam logic signed [PROD_W-1:0] GAIN     = 16'sd127;
    localparam logic signed [ACC_W-1:0]  SAT_MAX  = 18'sh07fff;
    localparam logic signed [ACC_W-1:0]  SAT_MIN  = -18'sh08000;

    // configuration register index (word address bit 2)
    localparam logic [0:0] CFG_PHASE_STEP = 1'b0;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_MEM_LOAD  = 2'd2
    } cmd_t;

    // register numbers within one voice group
    localparam logic [3:0] REG_START_LO = 4'd0;
    localparam logic [3:0] REG_START_HI = 4'd2;
    localparam logic [3:0] REG_END_LO   = 4'd4;
    localparam logic [3:0] REG_END_HI   = 4'd6;
    localparam logic [3:0] REG_KEY      = 4'd12;

    // microprogram addresses
    typedef enum logic [2:0] {
        UP_IDLE,
        UP_CHECK,
        UP_WAIT,
        UP_MUL,
        UP_ACC,
        UP_NEXT,
        UP_OUT
    } upc_t;

    // sequencing conditions
    typedef enum logic [2:0] {
        SEQ_NEXT,       // fall through to the next step
        SEQ_DISPATCH,   // jump on an accepted tick, else stay
        SEQ_SKIP,       // jump when the voice is idle or at its end
        SEQ_LOOP,       // jump back while voices remain, else fall through
        SEQ_HOLD        // stay while the output register holds an unclaimed mix, else jump
    } seq_t;

    typedef struct packed {
        seq_t seq;
        upc_t target;
        logic check;    // end check, memory read, position advance
        logic mul;      // scale the sample byte
        logic acc;      // add into the mix
        logic out;      // load the output register
    } ctrl_t;

    // control store
    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t w;
        w = '{seq: SEQ_NEXT, target: UP_IDLE, check: 1'b0, mul: 1'b0, acc: 1'b0, out: 1'b0};
        unique case (pc)
            UP_IDLE:
            begin
                w.seq = SEQ_DISPATCH;
                w.target = UP_CHECK;
            end
            UP_CHECK:
            begin
                w.seq = SEQ_SKIP;
                w.target = UP_NEXT;
                w.check = 1'b1;
            end
            UP_WAIT: w.seq = SEQ_NEXT;
            UP_MUL:  w.mul = 1'b1;
            UP_ACC:  w.acc = 1'b1;
            UP_NEXT:
            begin
                w.seq = SEQ_LOOP;
                w.target = UP_CHECK;
            end
            UP_OUT:
            begin
                w.seq = SEQ_HOLD;
                w.target = UP_IDLE;
                w.out = 1'b1;
            end
            default: w.seq = SEQ_HOLD;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fvpcm_ram.sv
// fvpcm_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module fvpcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/four_voice_pcm_sample_player.sv
// four_voice_pcm_sample_player: top level, voice registers, microcoded tick sequencer, mixer
// depends on rtl/fvpcm_pkg.sv and rtl/fvpcm_ram.sv
`default_nettype none

// Four-voice 8-bit PCM player. A register-write request or a sample-memory load request
// is applied when taken. A tick request runs a short microprogram that visits the voices
// one after another over the single read port of the sample memory: an end check for each
// voice, then for a voice that plays a read with position step, a wait for the read data,
// scale and accumulate, and a move to the next voice; the walk holds at its output step
// while the previous mix still sits unclaimed in the output register. The next request is
// taken once the microprogram is back at its idle step. The mix appears on both halves of
// m_axis_tdata. phase_step is written over the APB port at address 0; the user must do so
// only while the block is idle, which the block itself does not enforce; the sample memory
// has no reset and must be loaded before any voice reads it.
module four_voice_pcm_sample_player #(
    parameter int SAMPLE_ADDR_BITS = fvpcm_pkg::SAMPLE_ADDR_BITS_DEF,
    parameter int VOICE_COUNT      = fvpcm_pkg::VOICE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // reg_offset[5:0], reg_data[13:6],
                                            // mem_address[33:14], mem_byte[41:34], zeros
    input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
    // mixed samples
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // left_sample[15:0], right_sample[31:16]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

    // input field split
    logic [fvpcm_pkg::OFS_W-1:0]  reg_offset;
    logic [fvpcm_pkg::BYTE_W-1:0] reg_data;
    logic [fvpcm_pkg::ADDR_W-1:0] mem_address;
    logic [fvpcm_pkg::BYTE_W-1:0] mem_byte;
    fvpcm_pkg::cmd_t              command;

    assign reg_offset  = s_axis_tdata[5:0];
    assign reg_data    = s_axis_tdata[13:6];
    assign mem_address = s_axis_tdata[33:14];
    assign mem_byte    = s_axis_tdata[41:34];
    assign command     = fvpcm_pkg::cmd_t'(s_axis_tuser);

    // state
    fvpcm_pkg::upc_t                upc_reg;
    logic [VIDX_W-1:0]              voice_reg;
    logic [fvpcm_pkg::STEP_W-1:0]   phase_step_reg;
    logic [fvpcm_pkg::HI_W-1:0]     start_reg [VOICE_COUNT];
    logic [fvpcm_pkg::HI_W-1:0]     end_reg [VOICE_COUNT];
    logic [fvpcm_pkg::POS_W-1:0]    pos_reg [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]         playing_reg;
    logic signed [fvpcm_pkg::PROD_W-1:0] prod_reg;
    logic signed [fvpcm_pkg::ACC_W-1:0]  acc_reg;
    logic                           m_valid_reg;
    logic [fvpcm_pkg::SAMPLE_W-1:0] m_sample_reg;

    // control word of the current step
    fvpcm_pkg::ctrl_t ctrl;
    assign ctrl = fvpcm_pkg::ucode(upc_reg);

    // handshakes
    logic in_take;
    logic tick_take;
    logic load_take;
    logic write_take;
    logic out_free;

    assign s_axis_tready = (upc_reg == fvpcm_pkg::UP_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign tick_take     = in_take && (command == fvpcm_pkg::CMD_TICK);
    assign load_take     = in_take && (command == fvpcm_pkg::CMD_MEM_LOAD);
    assign write_take    = in_take && (command == fvpcm_pkg::CMD_REG_WRITE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // register write decode
    logic [1:0]        wr_voice;
    logic [VIDX_W-1:0] wr_idx;
    logic              wr_ok;

    assign wr_voice = reg_offset[5:4];
    assign wr_idx   = wr_voice[VIDX_W-1:0];
    assign wr_ok    = write_take && ({1'b0, wr_voice} < 3'(VOICE_COUNT));

    // current voice, end check
    logic [fvpcm_pkg::ADDR_W-1:0] cur_addr;
    logic [fvpcm_pkg::ADDR_W:0]   cur_reach;
    logic                         end_hit;
    logic                         cur_play;
    logic                         skip;
    logic                         rd_en;
    logic                         last_voice;

    assign cur_addr   = pos_reg[voice_reg][fvpcm_pkg::POS_W-1:fvpcm_pkg::FRAC_W];
    assign cur_reach  = {1'b0, cur_addr} + fvpcm_pkg::END_GUARD;
    assign end_hit    = cur_reach >= {1'b0, end_reg[voice_reg], 4'b0000};
    assign cur_play   = playing_reg[voice_reg];
    assign skip       = !cur_play || end_hit;
    assign rd_en      = ctrl.check && !skip;
    assign last_voice = (voice_reg == VIDX_W'(VOICE_COUNT - 1));

    // sample memory
    logic [fvpcm_pkg::BYTE_W-1:0] rd_byte;

    fvpcm_ram #(
        .WIDTH(fvpcm_pkg::BYTE_W),
        .DEPTH(MEM_DEPTH)
    ) u_sample_ram (
        .clk  (clk),
        .we   (load_take),
        .waddr(mem_address[SAMPLE_ADDR_BITS-1:0]),
        .wdata(mem_byte),
        .re   (rd_en),
        .raddr(cur_addr[SAMPLE_ADDR_BITS-1:0]),
        .rdata(rd_byte)
    );

    // scale and mix datapath
    logic signed [8:0]                  centered;
    logic signed [fvpcm_pkg::PROD_W-1:0] prod_next;
    logic signed [fvpcm_pkg::ACC_W-1:0]  acc_add;
    logic [fvpcm_pkg::SAMPLE_W-1:0]      sat_sample;

    assign centered  = {~rd_byte[7], ~rd_byte[7], rd_byte[6:0]};
    assign prod_next = centered * fvpcm_pkg::GAIN;
    assign acc_add   = acc_reg + {{4{prod_reg[15]}}, prod_reg[15:2]};

    always_comb
    begin
        if (acc_reg > fvpcm_pkg::SAT_MAX)
        begin
            sat_sample = fvpcm_pkg::SAT_MAX[fvpcm_pkg::SAMPLE_W-1:0];
        end
        else if (acc_reg < fvpcm_pkg::SAT_MIN)
        begin
            sat_sample = fvpcm_pkg::SAT_MIN[fvpcm_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            sat_sample = acc_reg[fvpcm_pkg::SAMPLE_W-1:0];
        end
    end

    // sequencer next address
    fvpcm_pkg::upc_t upc_next;

    always_comb
    begin
        upc_next = upc_reg;
        unique case (ctrl.seq)
            fvpcm_pkg::SEQ_NEXT:     upc_next = fvpcm_pkg::upc_t'(upc_reg + 3'd1);
            fvpcm_pkg::SEQ_DISPATCH: upc_next = tick_take ? ctrl.target : upc_reg;
            fvpcm_pkg::SEQ_SKIP:
                upc_next = skip ? ctrl.target : fvpcm_pkg::upc_t'(upc_reg + 3'd1);
            fvpcm_pkg::SEQ_LOOP:
                upc_next = last_voice ? fvpcm_pkg::upc_t'(upc_reg + 3'd1) : ctrl.target;
            fvpcm_pkg::SEQ_HOLD:     upc_next = out_free ? ctrl.target : upc_reg;
            default:                 upc_next = fvpcm_pkg::UP_IDLE;
        endcase
    end

    // control state, voice state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= fvpcm_pkg::UP_IDLE;
            voice_reg      <= '0;
            phase_step_reg <= fvpcm_pkg::PHASE_STEP_RST;
            playing_reg    <= '0;
            m_valid_reg    <= 1'b0;
            acc_reg        <= '0;
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                start_reg[v] <= '0;
                end_reg[v]   <= '0;
                pos_reg[v]   <= '0;
            end
        end
        else
        begin
            upc_reg <= upc_next;

            // configuration write
            if (psel && penable && pwrite && pready && (paddr[2] == fvpcm_pkg::CFG_PHASE_STEP))
            begin
                phase_step_reg <= pwdata[fvpcm_pkg::STEP_W-1:0];
            end

            // voice register writes
            if (wr_ok)
            begin
                case (reg_offset[3:0])
                    fvpcm_pkg::REG_START_LO: start_reg[wr_idx][7:0]  <= reg_data;
                    fvpcm_pkg::REG_START_HI: start_reg[wr_idx][15:8] <= reg_data;
                    fvpcm_pkg::REG_END_LO:   end_reg[wr_idx][7:0]    <= reg_data;
                    fvpcm_pkg::REG_END_HI:   end_reg[wr_idx][15:8]   <= reg_data;
                    fvpcm_pkg::REG_KEY:
                    begin
                        playing_reg[wr_idx] <= (reg_data != 8'd0);
                        pos_reg[wr_idx] <= {start_reg[wr_idx], 4'b0000, 8'd0};
                    end
                    default: ;
                endcase
            end

            // voice walk starts at voice zero with an empty mix
            if (upc_reg == fvpcm_pkg::UP_IDLE)
            begin
                voice_reg <= '0;
                acc_reg   <= '0;
            end

            // end check: stop, or read and step
            if (ctrl.check && cur_play)
            begin
                if (end_hit)
                begin
                    playing_reg[voice_reg] <= 1'b0;
                end
                else
                begin
                    pos_reg[voice_reg] <= pos_reg[voice_reg]
                        + {{(fvpcm_pkg::POS_W - fvpcm_pkg::STEP_W){1'b0}}, phase_step_reg};
                end
            end

            if (ctrl.acc)
            begin
                acc_reg <= acc_add;
            end

            if (ctrl.seq == fvpcm_pkg::SEQ_LOOP && !last_voice)
            begin
                voice_reg <= voice_reg + VIDX_W'(1);
            end

            // output register
            if (ctrl.out && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.out && out_free)
        begin
            m_sample_reg <= sat_sample;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_sample_reg, m_sample_reg};

    // configuration read
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fvpcm_pkg::CFG_PHASE_STEP) ? {16'd0, phase_step_reg} : 32'd0;

    // checks
    a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(upc_reg) == fvpcm_pkg::UP_OUT)
        else $error("output valid raised outside the output step");

    a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |=> (upc_reg == fvpcm_pkg::UP_CHECK) && (voice_reg == '0))
        else $error("tick did not start the voice walk at voice zero");

    a_voice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, voice_reg} < (VIDX_W + 1)'(VOICE_COUNT))
        else $error("voice index beyond the voice count");

    a_mul_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == fvpcm_pkg::UP_MUL |-> $past(upc_reg, 2) == fvpcm_pkg::UP_CHECK)
        else $error("scale step without a sample read two cycles before");

    a_mix_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg <= fvpcm_pkg::ACC_W'(VOICE_COUNT * 4032))
        && (acc_reg >= -fvpcm_pkg::ACC_W'(VOICE_COUNT * 4064)))
        else $error("mix accumulator out of the reachable range");

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench: directed table and random requests for four_voice_pcm_sample_player
// depends on rtl/fvpcm_pkg.sv and rtl/four_voice_pcm_sample_player.sv
// every mixed sample is checked against a voice model kept inside this file or a typed mix
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_REG_WRITE   = fvpcm_pkg::CMD_REG_WRITE;
    localparam logic [1:0] CMD_TICK        = fvpcm_pkg::CMD_TICK;
    localparam logic [1:0] CMD_MEM_LOAD    = fvpcm_pkg::CMD_MEM_LOAD;
    localparam logic [3:0] REG_START_LO    = fvpcm_pkg::REG_START_LO;
    localparam logic [3:0] REG_START_HI    = fvpcm_pkg::REG_START_HI;
    localparam logic [3:0] REG_END_LO      = fvpcm_pkg::REG_END_LO;
    localparam logic [3:0] REG_END_HI      = fvpcm_pkg::REG_END_HI;
    localparam logic [3:0] REG_KEY         = fvpcm_pkg::REG_KEY;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [3:0] REG_SPARE       = 4'd8;
    localparam logic [3:0] REG_LAST        = 4'd15;
    localparam logic [2:0] PHASE_STEP_ADDR = 3'd0;
    localparam int         DRAIN_CYCLES    = 30;
    localparam int         PHASE_COUNT     = 8;
    localparam int         PHASE_BUDGET    = 165;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  ofs;
        logic [7:0]  data;
        logic [19:0] addr;
        logic [7:0]  sample;
        bit          fixed;
        logic [15:0] mix;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // reg_offset[5:0], reg_data[13:6], mem_address[33:14],
                                // mem_byte[41:34], zeros
    logic [1:0]  s_axis_tuser;  // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // left_sample[15:0], right_sample[31:16]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // voice model state
    logic [15:0] phase_step;
    logic [19:0] v_start [4];
    logic [19:0] v_end [4];
    logic [27:0] v_pos [4];
    bit          v_playing [4];
    logic [7:0]  sample_mem [int];

    logic [15:0] expected_mix_q [$];
    logic [15:0] want_mix;
    int          errors = 0;
    int          sent_count = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          rcv_cycles = 0;

    // directed requests; a typed mix is used where it is obvious
    request_row_t directed_rows [26] = '{
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b1, 16'h0000},
        '{CMD_REG_WRITE, {2'd0, REG_START_LO},  8'h10, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd0, REG_START_HI},  8'h00, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd0, REG_END_LO},    8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd0, REG_END_HI},    8'h00, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_MEM_LOAD,  6'h00,                 8'h00, 20'h00100, 8'hFF, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd0, REG_KEY},       8'h01, 20'h00000, 8'h00, 1'b0, 16'h0000},
        // full-scale positive byte
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b1, 16'h0FC0},
        '{CMD_MEM_LOAD,  6'h00,                 8'h00, 20'h00100, 8'h00, 1'b0, 16'h0000},
        // full-scale negative byte
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b1, 16'hF020},
        '{CMD_MEM_LOAD,  6'h00,                 8'h00, 20'h00100, 8'h80, 1'b0, 16'h0000},
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b1, 16'h0000},
        // voice 3 at the top of memory stops at once
        '{CMD_REG_WRITE, {2'd3, REG_START_LO},  8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd3, REG_START_HI},  8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd3, REG_END_LO},    8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd3, REG_END_HI},    8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd3, REG_KEY},       8'hFF, 20'h00000, 8'h00, 1'b0, 16'h0000},
        // voice 1 with an end address below the guard distance
        '{CMD_REG_WRITE, {2'd1, REG_END_LO},    8'h01, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd1, REG_KEY},       8'h80, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b0, 16'h0000},
        // ignored registers and command, and a load at the top address
        '{CMD_REG_WRITE, {2'd0, REG_SPARE},     8'h5A, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_REG_WRITE, {2'd2, REG_LAST},      8'hC3, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_UNUSED,    6'h3F,                 8'hFF, 20'hFFFFF, 8'hFF, 1'b0, 16'h0000},
        '{CMD_MEM_LOAD,  6'h3F,                 8'hFF, 20'hFFFFF, 8'hA5, 1'b0, 16'h0000},
        // key off leaves every voice silent
        '{CMD_REG_WRITE, {2'd0, REG_KEY},       8'h00, 20'h00000, 8'h00, 1'b0, 16'h0000},
        '{CMD_TICK,      6'h00,                 8'h00, 20'h00000, 8'h00, 1'b1, 16'h0000}
    };

    four_voice_pcm_sample_player u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // voice model: applies one request, returns 1 with the mix for a tick
    function automatic bit predict_request(input logic [1:0] cmd, input logic [5:0] ofs,
                                           input logic [7:0] data, input logic [19:0] addr,
                                           input logic [7:0] sample, output logic [15:0] mix);
        int          sum;
        int          d;
        int unsigned v;
        logic [19:0] rd;
        mix = '0;
        sum = 0;
        if (cmd == CMD_REG_WRITE)
        begin
            v = ofs[5:4];
            case (ofs[3:0])
                REG_START_LO: v_start[v] = {v_start[v][19:12], data, 4'h0};
                REG_START_HI: v_start[v] = {data, v_start[v][11:4], 4'h0};
                REG_END_LO:   v_end[v] = {v_end[v][19:12], data, 4'h0};
                REG_END_HI:   v_end[v] = {data, v_end[v][11:4], 4'h0};
                REG_KEY:
                begin
                    v_playing[v] = (data != 8'h00);
                    v_pos[v] = {v_start[v], 8'h00};
                end
                default: ;
            endcase
            return 1'b0;
        end
        if (cmd == CMD_MEM_LOAD)
        begin
            sample_mem[int'(addr)] = sample;
            return 1'b0;
        end
        if (cmd != CMD_TICK)
            return 1'b0;
        // each playing voice: end check, then read, scale and step
        for (int i = 0; i < fvpcm_pkg::VOICE_COUNT_DEF; i++)
        begin
            if (!v_playing[i])
                continue;
            rd = v_pos[i][27:8];
            if (int'(rd) + 32 >= int'(v_end[i]))
            begin
                v_playing[i] = 1'b0;
                continue;
            end
            d = int'(sample_mem[int'(rd)]) - 128;
            v_pos[i] = v_pos[i] + phase_step;
            sum += (d * 127) >>> 2;
        end
        if (sum > 32767)
            sum = 32767;
        else if (sum < -32768)
            sum = -32768;
        mix = sum[15:0];
        return 1'b1;
    endfunction

    // one request on the input stream, with bursts and gaps
    task automatic drive_request(input logic [1:0] cmd, input logic [5:0] ofs,
                                 input logic [7:0] data, input logic [19:0] addr,
                                 input logic [7:0] sample);
        int gap;
        if (burst_left == 0)
        begin
            gap = ((sent_count / 400) % 3 == 2) ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'h00, sample, addr, data, ofs};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent_count++;
    endtask

    // predict and send; a tick first gets loads for any byte it would read unwritten
    task automatic issue(input logic [1:0] cmd, input logic [5:0] ofs, input logic [7:0] data,
                         input logic [19:0] addr, input logic [7:0] sample,
                         input bit fixed, input logic [15:0] fixed_mix);
        logic [15:0] mix;
        logic [19:0] rd;
        logic [7:0]  fill;
        logic [5:0]  junk_ofs;
        logic [7:0]  junk_data;
        if (cmd == CMD_TICK)
        begin
            for (int i = 0; i < fvpcm_pkg::VOICE_COUNT_DEF; i++)
            begin
                rd = v_pos[i][27:8];
                if (v_playing[i] && int'(rd) + 32 < int'(v_end[i])
                    && !sample_mem.exists(int'(rd)))
                begin
                    fill      = 8'($urandom);
                    junk_ofs  = 6'($urandom);
                    junk_data = 8'($urandom);
                    void'(predict_request(CMD_MEM_LOAD, junk_ofs, junk_data, rd, fill, mix));
                    drive_request(CMD_MEM_LOAD, junk_ofs, junk_data, rd, fill);
                end
            end
        end
        if (predict_request(cmd, ofs, data, addr, sample, mix))
            expected_mix_q.push_back(fixed ? fixed_mix : mix);
        drive_request(cmd, ofs, data, addr, sample);
    endtask

    // hold the sender until every mix is out and the block has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_mix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // apb write of phase_step
    task automatic write_phase_step(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PHASE_STEP_ADDR;
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        phase_step = value;
    endtask

    // apb read of phase_step against the model
    task automatic check_phase_step();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PHASE_STEP_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== phase_step)
        begin
            $error("phase_step expected %0d actual %0d", phase_step, prdata[15:0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver: calm stretches, then random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rcv_cycles++;
                if (rcv_cycles % 3000 >= 1000 && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 30);
            end
        end
    end

    // compare each mixed sample with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_mix_q.size() == 0)
            begin
                $error("mixed sample %0d with none expected", $signed(m_axis_tdata[15:0]));
                errors++;
            end
            else
            begin
                want_mix = expected_mix_q.pop_front();
                if (m_axis_tdata[15:0] !== want_mix)
                begin
                    $error("left_sample expected %0d actual %0d", $signed(want_mix),
                           $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[31:16] !== want_mix)
                begin
                    $error("right_sample expected %0d actual %0d", $signed(want_mix),
                           $signed(m_axis_tdata[31:16]));
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        int          pick;
        int          ticks;
        int          len;
        int          phase_end;
        logic [1:0]  voice;
        logic [19:0] seg_start;
        logic [19:0] seg_end;
        logic [15:0] step;
        logic [15:0] step_plan [6];

        step_plan = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h1000, 16'h0040};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        phase_step    = fvpcm_pkg::PHASE_STEP_RST;
        for (int i = 0; i < fvpcm_pkg::VOICE_COUNT_DEF; i++)
        begin
            v_start[i]   = '0;
            v_end[i]     = '0;
            v_pos[i]     = '0;
            v_playing[i] = 1'b0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_phase_step();

        // directed table
        foreach (directed_rows[i])
            issue(directed_rows[i].cmd, directed_rows[i].ofs, directed_rows[i].data,
                  directed_rows[i].addr, directed_rows[i].sample, directed_rows[i].fixed,
                  directed_rows[i].mix);

        // random phases, each with its own phase_step
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            step = (p < 6) ? step_plan[p] : 16'($urandom);
            write_phase_step(step);
            @(negedge clk);
            check_phase_step();
            phase_end = sent_count + PHASE_BUDGET;
            while (sent_count < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // program one voice, key it and let it play
                    voice     = 2'($urandom);
                    seg_start = {16'($urandom), 4'h0};
                    case ($urandom_range(0, 9))
                        0:       seg_end = {16'($urandom), 4'h0};
                        1:       len = $urandom_range(0, 2);
                        default: len = $urandom_range(3, 96);
                    endcase
                    if (seg_end === 'x || pick % 10 != 0)
                        seg_end = seg_start + 20'(len * 16);
                    issue(CMD_REG_WRITE, {voice, REG_START_LO}, seg_start[11:4],
                          20'($urandom), 8'($urandom), 1'b0, '0);
                    issue(CMD_REG_WRITE, {voice, REG_START_HI}, seg_start[19:12],
                          20'($urandom), 8'($urandom), 1'b0, '0);
                    issue(CMD_REG_WRITE, {voice, REG_END_LO}, seg_end[11:4],
                          20'($urandom), 8'($urandom), 1'b0, '0);
                    issue(CMD_REG_WRITE, {voice, REG_END_HI}, seg_end[19:12],
                          20'($urandom), 8'($urandom), 1'b0, '0);
                    issue(CMD_REG_WRITE, {voice, REG_KEY},
                          ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                          20'($urandom), 8'($urandom), 1'b0, '0);
                    ticks = $urandom_range(1, 16);
                    repeat (ticks)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            issue(CMD_REG_WRITE, 6'($urandom), 8'($urandom), 20'($urandom),
                                  8'($urandom), 1'b0, '0);
                        issue(CMD_TICK, 6'($urandom), 8'($urandom), 20'($urandom),
                              8'($urandom), 1'b0, '0);
                    end
                end
                else if (pick < 70)
                    issue(CMD_TICK, 6'($urandom), 8'($urandom), 20'($urandom),
                          8'($urandom), 1'b0, '0);
                else if (pick < 80)
                    issue(CMD_MEM_LOAD, 6'($urandom), 8'($urandom), 20'($urandom),
                          8'($urandom), 1'b0, '0);
                else if (pick < 95)
                    issue(CMD_REG_WRITE, 6'($urandom), 8'($urandom), 20'($urandom),
                          8'($urandom), 1'b0, '0);
                else
                    issue(CMD_UNUSED, 6'($urandom), 8'($urandom), 20'($urandom),
                          8'($urandom), 1'b0, '0);
            end
        end

        // drain and report
        wait_drained();
        if (errors == 0 && expected_mix_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
